[sv/csfc_pkg.sv]
// types, widths and constants shared by the cube shadow face culler
`timescale 1ns / 1ps
`default_nettype none

package csfc_pkg;

    localparam int COORD_BITS = 32;
    localparam int TYPE_BITS  = 16;
    localparam int ID_BITS    = 32;
    localparam int FACES      = 6;
    localparam int PLANES     = 6;
    localparam int AXES       = 3;

    // doubled center and doubled extent widths
    localparam int CW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 1;
    // plane distance and radius width
    localparam int DW = COORD_BITS + 4;

    localparam int CFG_W   = (COORD_BITS > TYPE_BITS) ? COORD_BITS : TYPE_BITS;
    localparam int CFG_IDX = 3;

    typedef logic [CFG_IDX-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BOX_MIN_X      = 3'd0;
    localparam t_cfg_idx CFG_BOX_MIN_Y      = 3'd1;
    localparam t_cfg_idx CFG_BOX_MIN_Z      = 3'd2;
    localparam t_cfg_idx CFG_BOX_MAX_X      = 3'd3;
    localparam t_cfg_idx CFG_BOX_MAX_Y      = 3'd4;
    localparam t_cfg_idx CFG_BOX_MAX_Z      = 3'd5;
    localparam t_cfg_idx CFG_REQUIRED_TYPES = 3'd6;

    // plane normals as per-axis masks of +1 and -1 components (bit 0 x, 1 y, 2 z)
    localparam logic [AXES-1:0] PLANE_POS [PLANES] = '{
        3'b010, 3'b011, 3'b101, 3'b001, 3'b110, 3'b100
    };
    localparam logic [AXES-1:0] PLANE_NEG [PLANES] = '{
        3'b001, 3'b000, 3'b000, 3'b100, 3'b000, 3'b010
    };

    localparam logic [FACES-1:0] ALL_FACES = '1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] obj_min_x;
        logic signed [COORD_BITS-1:0] obj_min_y;
        logic signed [COORD_BITS-1:0] obj_min_z;
        logic signed [COORD_BITS-1:0] obj_max_x;
        logic signed [COORD_BITS-1:0] obj_max_y;
        logic signed [COORD_BITS-1:0] obj_max_z;
        logic [TYPE_BITS-1:0]         type_flags;
        logic                         can_cull;
        logic [ID_BITS-1:0]           object_id;
    } t_obj;

    typedef struct packed {
        logic [FACES-1:0]   face_mask;
        logic               seen_any;
        logic [ID_BITS-1:0] result_id;
    } t_res;

    // first stage results handed to the plane tests
    typedef struct packed {
        logic [AXES-1:0][CW-1:0] c;
        logic [AXES-1:0][EW-1:0] e;
        logic [AXES-1:0]         above;
        logic [AXES-1:0]         below;
        logic                    ok;
        logic                    can_cull;
        logic [ID_BITS-1:0]      id;
    } t_s1;

endpackage

`default_nettype wire

[sv/csfc_if.sv]
// valid/ready channel interfaces for objects and face results
`timescale 1ns / 1ps
`default_nettype none

interface csfc_obj_if import csfc_pkg::*; ();
    logic valid;
    logic ready;
    t_obj data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface csfc_res_if import csfc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/cube_shadow_face_culler.sv]
// top level: culls object boxes against a light box for six cube-map faces
//
//  channel   dir  handshake        payload
//  i_obj     in   valid / ready    object box, type flags, can_cull, id
//  o_res     out  valid / ready    face mask, seen_any, result id
//  i_cfg_*   in   write enable     register index, write data
//
// one transaction per cycle sustained while o_res is ready; a result passes
// the input register, box stage and result register after its object is taken
// a stall on o_res backs up through the three stages, each stage still
// taking a new transaction when the one ahead of it moves on
// reset clears the stage valid bits and the light box and type registers
`timescale 1ns / 1ps
`default_nettype none

module cube_shadow_face_culler import csfc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_idx         i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    csfc_obj_if.sink              i_obj,
    csfc_res_if.source            o_res
);

    logic signed [COORD_BITS-1:0] r_lmin [AXES];
    logic signed [COORD_BITS-1:0] r_lmax [AXES];
    logic [TYPE_BITS-1:0]         r_req_types;

    logic r_in_valid;
    t_obj r_in;
    logic r_s1_valid;
    t_s1  r_s1;
    logic r_out_valid;
    t_res r_out;

    t_s1  n_s1;
    t_res n_out;

    logic in_ready;
    logic s1_ready;
    logic out_ready;

    logic signed [COORD_BITS-1:0] omin [AXES];
    logic signed [COORD_BITS-1:0] omax [AXES];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_lmin[a] <= '0;
                r_lmax[a] <= '0;
            end
            r_req_types <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOX_MIN_X:      r_lmin[0]   <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_MIN_Y:      r_lmin[1]   <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_MIN_Z:      r_lmin[2]   <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_MAX_X:      r_lmax[0]   <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_MAX_Y:      r_lmax[1]   <= i_cfg_data[COORD_BITS-1:0];
                CFG_BOX_MAX_Z:      r_lmax[2]   <= i_cfg_data[COORD_BITS-1:0];
                CFG_REQUIRED_TYPES: r_req_types <= i_cfg_data[TYPE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage handshakes
    assign out_ready   = !r_out_valid || o_res.ready;
    assign s1_ready    = !r_s1_valid || out_ready;
    assign in_ready    = !r_in_valid || s1_ready;
    assign i_obj.ready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_obj.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_obj.valid) begin
            r_in <= i_obj.data;
        end
    end

    // box stage: doubled center, doubled extent, overlap, type match and axis side
    assign omin[0] = r_in.obj_min_x;
    assign omin[1] = r_in.obj_min_y;
    assign omin[2] = r_in.obj_min_z;
    assign omax[0] = r_in.obj_max_x;
    assign omax[1] = r_in.obj_max_y;
    assign omax[2] = r_in.obj_max_z;

    always_comb begin
        logic signed [COORD_BITS:0] lsum;
        logic signed [COORD_BITS:0] osum;
        logic signed [COORD_BITS:0] omax2;
        logic signed [COORD_BITS:0] omin2;
        logic                       overlap;
        overlap = 1'b1;
        n_s1 = '0;
        for (int a = 0; a < AXES; a++) begin
            lsum  = (COORD_BITS+1)'(r_lmin[a]) + (COORD_BITS+1)'(r_lmax[a]);
            osum  = (COORD_BITS+1)'(omin[a]) + (COORD_BITS+1)'(omax[a]);
            omax2 = {omax[a], 1'b0};
            omin2 = {omin[a], 1'b0};
            n_s1.c[a]     = CW'(osum) - CW'(lsum);
            n_s1.e[a]     = EW'(omax[a]) - EW'(omin[a]);
            n_s1.above[a] = omax2 > lsum;
            n_s1.below[a] = omin2 < lsum;
            if (!(r_lmin[a] <= omax[a] && omin[a] <= r_lmax[a])) begin
                overlap = 1'b0;
            end
        end
        n_s1.ok       = overlap && ((r_in.type_flags & r_req_types) == r_req_types);
        n_s1.can_cull = r_in.can_cull;
        n_s1.id       = r_in.object_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && r_in_valid) begin
            r_s1 <= n_s1;
        end
    end

    // plane stage and result register
    csfc_plane_test u_plane_test (
        .i_s1  (r_s1),
        .o_res (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

[sv/csfc_plane_test.sv]
// diagonal plane tests and face mask assembly
`timescale 1ns / 1ps
`default_nettype none

module csfc_plane_test import csfc_pkg::*; (
    input  t_s1  i_s1,
    output t_res o_res
);

    logic [PLANES-1:0] rp;
    logic [PLANES-1:0] rn;
    logic [FACES-1:0]  mask;

    always_comb begin
        logic signed [DW-1:0] d_sum;
        logic signed [DW-1:0] r_sum;
        for (int j = 0; j < PLANES; j++) begin
            d_sum = '0;
            r_sum = '0;
            for (int a = 0; a < AXES; a++) begin
                if (PLANE_POS[j][a]) begin
                    d_sum = d_sum + DW'($signed(i_s1.c[a]));
                end
                if (PLANE_NEG[j][a]) begin
                    d_sum = d_sum - DW'($signed(i_s1.c[a]));
                end
                if (PLANE_POS[j][a] | PLANE_NEG[j][a]) begin
                    r_sum = r_sum + DW'($signed(i_s1.e[a]));
                end
            end
            rp[j] = d_sum > -r_sum;
            rn[j] = d_sum < r_sum;
        end
    end

    always_comb begin
        mask = '0;
        if (i_s1.ok) begin
            if (!i_s1.can_cull) begin
                mask = ALL_FACES;
            end else begin
                mask[0] = rn[0] & rp[1] & rp[2] & rp[3] & i_s1.above[0];
                mask[1] = rp[0] & rn[1] & rn[2] & rn[3] & i_s1.below[0];
                mask[2] = rp[0] & rp[1] & rp[4] & rn[5] & i_s1.above[1];
                mask[3] = rn[0] & rn[1] & rn[4] & rp[5] & i_s1.below[1];
                mask[4] = rp[2] & rn[3] & rp[4] & rp[5] & i_s1.above[2];
                mask[5] = rn[2] & rp[3] & rn[4] & rn[5] & i_s1.below[2];
            end
        end
    end

    assign o_res.face_mask = mask;
    assign o_res.seen_any  = |mask;
    assign o_res.result_id = i_s1.id;

endmodule

`default_nettype wire
